// File: rtl/core/bfa_pkg.sv
// Shared constants, codes and types of the bitmap frame allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bfa_pkg;

  // Bitmap geometry
  localparam int FRAME_CAPACITY = 65536;
  localparam int WORD_W         = 64;
  localparam int BIT_IDX_W      = $clog2(WORD_W);
  localparam int WORDS          = (FRAME_CAPACITY + WORD_W - 1) / WORD_W;
  localparam int WADDR_W        = $clog2(WORDS);
  localparam int CNT_W          = $clog2(WORDS + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int FRAME_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 17;

  // Frame limit arithmetic is wide enough for both the register and the capacity
  localparam int CAP_W = $clog2(FRAME_CAPACITY + 1);
  localparam int LIM_W = (CAP_W > CFG_W) ? CAP_W : CFG_W;
  localparam logic [LIM_W-1:0] CAP_LIMIT = LIM_W'(FRAME_CAPACITY);

  // Register port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_FRAMES = REG_IDX_W'(0);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  typedef logic [WORD_W-1:0]  bfa_word_t;
  typedef logic [WADDR_W-1:0] bfa_waddr_t;

  // Command to the word update unit
  typedef struct packed {
    logic                 alloc;    // use the first clear bit
    logic                 clear;    // clear instead of set
    logic [BIT_IDX_W-1:0] bit_idx;  // bit for free / reserve
  } bfa_wop_t;

  // Search result of the word update unit
  typedef struct packed {
    logic                 full;
    logic [BIT_IDX_W-1:0] free_idx;
  } bfa_wres_t;

endpackage

`default_nettype wire

// File: rtl/core/bfa_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on bfa_pkg.
`default_nettype none

interface bfa_in_if;
  import bfa_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FRAME_W-1:0] frame_number;

  modport source (output valid, op, frame_number, input ready);
  modport sink   (input valid, op, frame_number, output ready);
endinterface

interface bfa_out_if;
  import bfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  granted_frame;

  modport source (output valid, status, granted_frame, input ready);
  modport sink   (input valid, status, granted_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bfa_bitmap_mem.sv
// Usage bitmap storage: one write port, one read port with registered data.
// Depends on bfa_pkg.
`default_nettype none

module bfa_bitmap_mem (
  input  logic                clk,
  input  logic                wr_en,
  input  bfa_pkg::bfa_waddr_t wr_addr,
  input  bfa_pkg::bfa_word_t  wr_data,
  input  bfa_pkg::bfa_waddr_t rd_addr,
  output bfa_pkg::bfa_word_t  rd_data
);
  import bfa_pkg::*;

  bfa_word_t mem [WORDS];
  bfa_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: rtl/core/bfa_word_unit.sv
// Shared word update unit: first-clear-bit search plus single-bit set/clear.
// Depends on bfa_pkg.
`default_nettype none

module bfa_word_unit (
  input  bfa_pkg::bfa_word_t  word_in,
  input  bfa_pkg::bfa_wop_t   wop,
  output bfa_pkg::bfa_wres_t  wres,
  output bfa_pkg::bfa_word_t  word_out
);
  import bfa_pkg::*;

  localparam int GRP_W     = 8;
  localparam int NGRP      = WORD_W / GRP_W;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int GRP_SEL_W = $clog2(NGRP);

  logic [NGRP-1:0]      grp_full;
  logic [GRP_IDX_W-1:0] grp_idx [NGRP];
  logic [GRP_SEL_W-1:0] grp_sel;
  logic [BIT_IDX_W-1:0] sel_bit;
  bfa_word_t            mask;

  // Two-level search: lowest clear bit inside each byte, then lowest non-full byte
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_full[g] = &word_in[g*GRP_W +: GRP_W];
      grp_idx[g]  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!word_in[g*GRP_W + b]) begin
          grp_idx[g] = GRP_IDX_W'(b);
        end
      end
    end
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (!grp_full[g]) begin
        grp_sel = GRP_SEL_W'(g);
      end
    end
  end

  assign wres.full     = &word_in;
  assign wres.free_idx = {grp_sel, grp_idx[grp_sel]};

  assign sel_bit  = wop.alloc ? wres.free_idx : wop.bit_idx;
  assign mask     = WORD_W'(1) << sel_bit;
  assign word_out = wop.clear ? (word_in & ~mask) : (word_in | mask);

endmodule

`default_nettype wire

// File: rtl/core/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator: sequencer, register port,
// result register. Depends on bfa_pkg, bfa_if, bfa_bitmap_mem, bfa_word_unit.
`default_nettype none

// One usage bit per physical frame (1 = in use or reserved), kept as 64-bit
// words in a single-port-read bitmap memory. After reset the block runs a
// clearing pass that writes every word to all ones, one word per cycle
// (WORDS = 1024 words); in_ch.ready stays low until it is finished, while
// register writes are taken as usual. total_frames (register 0, byte address
// 0) bounds free requests and the allocate scan and saturates at the
// capacity. Each request beat gives exactly one result beat. Allocate reads
// one bitmap word per cycle through the shared word unit, examining up to
// floor(total_frames / 64) words, at most 1024. A rejected or failed request
// reports granted_frame 0. The result sits in an output register, so a
// finished beat may wait on out_ch.ready while the next request is accepted.

module bitmap_frame_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  bfa_in_if.sink                             in_ch,
  bfa_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bfa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bfa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import bfa_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;  // fill bitmap with ones
  localparam logic [1:0] S_IDLE  = 2'd1;  // wait for a request beat
  localparam logic [1:0] S_CHK   = 2'd2;  // word in hand: update or scan on
  localparam logic [1:0] S_FIN   = 2'd3;  // hand result to output register

  logic [1:0]          state_r, state_nxt;
  bfa_waddr_t          addr_r, addr_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [FRAME_W-1:0]  fr_r, fr_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [FRAME_W-1:0]  res_grant_r, res_grant_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FRAME_W-1:0]  out_grant_r, out_grant_nxt;
  logic [CFG_W-1:0]    total_frames_r, total_frames_nxt;

  // Memory and word unit hookup
  logic       mem_wr_en;
  bfa_waddr_t mem_wr_addr;
  bfa_word_t  mem_wr_data;
  bfa_waddr_t mem_rd_addr;
  bfa_word_t  mem_rd_data;
  bfa_wop_t   wop;
  bfa_wres_t  wres;
  bfa_word_t  upd_word;

  // Request decode
  logic [LIM_W-1:0]     limit;
  logic [CNT_W-1:0]     words;
  logic [LIM_W-1:0]     in_fr_ext;
  logic                 free_ok;
  logic                 rsv_ok;
  bfa_waddr_t           in_waddr;
  logic [CNT_W-1:0]     scan_next;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  bfa_bitmap_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bfa_word_unit u_word (
    .word_in  (mem_rd_data),
    .wop      (wop),
    .wres     (wres),
    .word_out (upd_word)
  );

  // total_frames saturates at capacity; only whole words are scanned
  assign limit     = (LIM_W'(total_frames_r) > CAP_LIMIT) ? CAP_LIMIT
                                                          : LIM_W'(total_frames_r);
  assign words     = CNT_W'(limit >> BIT_IDX_W);
  assign in_fr_ext = LIM_W'(in_ch.frame_number);
  assign free_ok   = (in_ch.frame_number != '0) && (in_fr_ext < limit);
  assign rsv_ok    = in_fr_ext < CAP_LIMIT;
  assign in_waddr  = WADDR_W'(in_fr_ext >> BIT_IDX_W);
  assign scan_next = CNT_W'(addr_r) + CNT_W'(1);

  assign wop.alloc   = (op_r == OP_ALLOC);
  assign wop.clear   = (op_r == OP_FREE);
  assign wop.bit_idx = fr_r[BIT_IDX_W-1:0];

  // Register port
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_TOTAL_FRAMES) ? APB_DATA_W'(total_frames_r) : '0;

  always_comb begin
    total_frames_nxt = total_frames_r;
    if (cfg_wr && (reg_idx == REG_TOTAL_FRAMES)) begin
      total_frames_nxt = pwdata[CFG_W-1:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    op_nxt         = op_r;
    fr_nxt         = fr_r;
    res_status_nxt = res_status_r;
    res_grant_nxt  = res_grant_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = addr_r;
    mem_wr_data    = upd_word;
    mem_rd_addr    = addr_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = '1;
        addr_nxt    = addr_r + WADDR_W'(1);
        if (addr_r == WADDR_W'(WORDS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = in_ch.op;
          fr_nxt         = in_ch.frame_number;
          res_grant_nxt  = '0;
          res_status_nxt = ST_REJECT;
          state_nxt      = S_FIN;
          case (in_ch.op)
            OP_ALLOC: begin
              if (words == '0) begin
                res_status_nxt = ST_OOM;
              end else begin
                addr_nxt    = '0;
                mem_rd_addr = '0;
                state_nxt   = S_CHK;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                addr_nxt    = in_waddr;
                mem_rd_addr = in_waddr;
                state_nxt   = S_CHK;
              end
            end
            OP_RESERVE: begin
              if (rsv_ok) begin
                addr_nxt    = in_waddr;
                mem_rd_addr = in_waddr;
                state_nxt   = S_CHK;
              end
            end
            default: begin
              res_status_nxt = ST_REJECT;
            end
          endcase
        end
      end

      S_CHK: begin
        if (op_r == OP_ALLOC) begin
          if (wres.full) begin
            // word exhausted: fetch the next one, or give up at the end
            if (scan_next < words) begin
              addr_nxt    = WADDR_W'(scan_next);
              mem_rd_addr = WADDR_W'(scan_next);
            end else begin
              res_status_nxt = ST_OOM;
              state_nxt      = S_FIN;
            end
          end else begin
            mem_wr_en      = 1'b1;
            res_status_nxt = ST_DONE;
            res_grant_nxt  = FRAME_W'({addr_r, wres.free_idx});
            state_nxt      = S_FIN;
          end
        end else begin
          mem_wr_en      = 1'b1;
          res_status_nxt = ST_DONE;
          state_nxt      = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_grant_nxt  = res_grant_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      addr_r         <= '0;
      out_valid_r    <= 1'b0;
      total_frames_r <= '0;
    end else begin
      state_r        <= state_nxt;
      addr_r         <= addr_nxt;
      out_valid_r    <= out_valid_nxt;
      total_frames_r <= total_frames_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    fr_r         <= fr_nxt;
    res_status_r <= res_status_nxt;
    res_grant_r  <= res_grant_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_frame = out_grant_r;

  // Only a successful allocate carries a frame number
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_DONE)) |-> (out_grant_r == '0))
    else $error("nonzero granted_frame on a failed request");

  // The scan never runs past the covered words
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHK) && (op_r == OP_ALLOC)) |-> (CNT_W'(addr_r) < words))
    else $error("allocate scan beyond total_frames");

  // A granted allocation flips exactly one bitmap bit
  a_alloc_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHK) && (op_r == OP_ALLOC) && mem_wr_en)
      |-> ($countones(mem_wr_data ^ mem_rd_data) == 1))
    else $error("allocate changed other than one bit");

  // Bitmap is only written during the clearing pass or an update
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_FIN)) |-> !mem_wr_en)
    else $error("bitmap written outside an update");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for bitmap_frame_allocator: drives request beats and APB writes,
// predicts every result beat from its own copy of the frame bitmap and total_frames.
// Depends on bfa_pkg, bfa_if and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
  import bfa_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 5;
  // Longest quiet stretch allowed: the clearing pass after reset or one full
  // allocate scan plus the longest gap and stall, taken several times over.
  localparam int IDLE_LIMIT = 8000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_GAP = 10;
  localparam int MAX_REPORTS = 30;
  localparam int PHASES = 10;

  // Op code the block does not define; must answer with a rejected status.
  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
  // Register index with nothing behind it; writes to it are dropped.
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } alloc_reply_t;

  // Keeps the predicted bitmap and the replies still owed by the block.
  class frame_map_scoreboard;
    bit [WORD_W-1:0] usage_map [WORDS];
    bit [CFG_W-1:0]  total_frames;
    alloc_reply_t    replies_due [$];
    int              errors;

    function new();
      foreach (usage_map[w]) usage_map[w] = '1;
      total_frames = '0;
      errors = 0;
    endfunction

    // total_frames saturates at the capacity for both the scan and the free bound
    function int unsigned frame_limit();
      return (total_frames > FRAME_CAPACITY) ? FRAME_CAPACITY : int'(total_frames);
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_TOTAL_FRAMES) begin
        total_frames = value[CFG_W-1:0];
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Called once per accepted request beat; updates the bitmap and queues the reply.
    function void note_request(logic [OP_W-1:0] op, logic [FRAME_W-1:0] fr);
      alloc_reply_t r;
      int unsigned  lim;
      bit           found;
      r.status = ST_REJECT;
      r.frame  = '0;
      lim      = frame_limit();
      found    = 1'b0;
      case (op)
        OP_ALLOC: begin
          r.status = ST_OOM;
          // first fit over whole words only; a trailing partial word is never searched
          for (int w = 0; w < lim / WORD_W && !found; w++) begin
            if (usage_map[w] != '1) begin
              for (int b = 0; b < WORD_W && !found; b++) begin
                if (!usage_map[w][b]) begin
                  usage_map[w][b] = 1'b1;
                  r.status = ST_DONE;
                  r.frame  = FRAME_W'(w * WORD_W + b);
                  found    = 1'b1;
                end
              end
            end
          end
        end
        OP_FREE: begin
          // null frame and frames past the limit are refused
          if (fr != '0 && 32'(fr) < lim) begin
            usage_map[fr >> BIT_IDX_W][fr[BIT_IDX_W-1:0]] = 1'b0;
            r.status = ST_DONE;
          end
        end
        OP_RESERVE: begin
          // reserve is bounded by the capacity only, frame 0 included
          if (32'(fr) < FRAME_CAPACITY) begin
            usage_map[fr >> BIT_IDX_W][fr[BIT_IDX_W-1:0]] = 1'b1;
            r.status = ST_DONE;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [FRAME_W-1:0] granted);
      alloc_reply_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result beat with none pending: status %0d frame %0d",
                   $time, status, granted);
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
        if (granted !== want.frame) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: granted_frame expected %0d actual %0d", $time, want.frame, granted);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  frame_map_scoreboard sb;

  // Idle-free stretches: while set, the side drives back-to-back beats.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int quiet_cycles = 0;

  // Random phases: most use small totals, since an allocate that finds nothing
  // scans floor(total/64) words. Includes partial words, zero, sub-word and saturation.
  int unsigned phase_frames [PHASES] = '{64, 100, 1000, 0, 4096, 63, 65536, 131071, 2000, 1};
  int unsigned phase_items  [PHASES] = '{60, 60, 80, 20, 80, 30, 60, 40, 110, 20};

  bitmap_frame_allocator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: any accepted beat or register write counts as progress.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // One request beat. A gap of zero keeps valid high straight into the next beat,
  // so valid is never lowered and raised in the same step. The beat is noted at
  // the edge that accepts it, sampled before the block's own updates land.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fr);
    int gap;
    if ($urandom_range(0, 24) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.frame_number <= fr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, fr);
  endtask

  // Hold the sender off until every owed reply has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // APB write: setup then access; the register takes it at the access edge.
  // Only issued with the block idle, so no reply is in flight across a change.
  task automatic program_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_register(idx, value);
  endtask

  // Mostly well-formed traffic (allocate, in-range free and reserve) so frames
  // actually cycle through the bitmap; the rest is noise and edge frames.
  task automatic pick_request(output logic [OP_W-1:0] op, output logic [FRAME_W-1:0] fr);
    int unsigned lim;
    int unsigned roll;
    lim  = sb.frame_limit();
    roll = $urandom_range(0, 99);
    fr   = FRAME_W'($urandom);
    if (roll < 35) begin
      op = OP_ALLOC;                 // frame_number is don't-care, left random
    end else if (roll < 65 && lim > 1) begin
      op = OP_FREE;
      fr = FRAME_W'($urandom_range(1, lim - 1));
    end else if (roll < 78 && lim > 0) begin
      op = OP_RESERVE;
      fr = FRAME_W'($urandom_range(0, lim - 1));
    end else begin
      case ($urandom_range(0, 4))
        0: op = OP_FREE;             // anywhere in the 16-bit space
        1: op = OP_RESERVE;
        2: op = OP_UNDEFINED;
        3: begin
          op = OP_FREE;
          fr = '0;
        end
        default: begin
          op = OP_FREE;              // first frame past the limit
          fr = FRAME_W'(lim);
        end
      endcase
    end
  endtask

  // Result side: random stalls with ready, checked at the accepting edge.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.status, out_ch.granted_frame);
    end
  end

  initial begin
    logic [OP_W-1:0]    op;
    logic [FRAME_W-1:0] fr;
    sb = new();
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_ALLOC;
    in_ch.frame_number <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // total_frames is 0 out of reset: nothing to search, nothing freeable.
    // These sit behind the clearing pass until the block raises ready.
    send_beat(OP_ALLOC, 16'h0000);      // out of memory, zero words scanned
    send_beat(OP_FREE, 16'h0000);       // null frame
    send_beat(OP_FREE, 16'h0005);       // at or past total_frames
    send_beat(OP_RESERVE, 16'h0000);    // reserve takes frame 0 ...
    send_beat(OP_RESERVE, 16'hFFFF);    // ... and any frame below capacity
    send_beat(OP_UNDEFINED, 16'hFFFF);  // unknown op, rejected

    // 200 frames: three whole words plus a partial word that allocate never scans
    program_register(REG_TOTAL_FRAMES, 32'd200);
    send_beat(OP_FREE, 16'd1);
    send_beat(OP_FREE, 16'd199);        // in the partial word
    send_beat(OP_FREE, 16'd200);        // first frame past the limit
    send_beat(OP_FREE, 16'd1);          // already clear, still done
    send_beat(OP_ALLOC, 16'hFFFF);      // gets frame 1
    send_beat(OP_ALLOC, 16'h0000);      // 199 is not reachable: out of memory
    send_beat(OP_RESERVE, 16'd1);       // already set, still done
    send_beat(OP_FREE, 16'd63);
    send_beat(OP_FREE, 16'd64);
    send_beat(OP_ALLOC, 16'h0000);      // 63, last bit of word 0
    send_beat(OP_ALLOC, 16'h0000);      // 64, first bit of word 1
    program_register(REG_UNUSED, 32'hFFFF_FFFF);
    send_beat(OP_ALLOC, 16'h0000);      // unused register left the limit alone

    // Largest register value saturates at the capacity
    program_register(REG_TOTAL_FRAMES, 32'h0001_FFFF);
    send_beat(OP_FREE, 16'hFFFF);       // last frame of the capacity
    send_beat(OP_ALLOC, 16'h0000);      // word 3 now scanned: 199 comes first
    send_beat(OP_ALLOC, 16'h0000);      // full scan down to 65535

    for (int p = 0; p < PHASES; p++) begin
      program_register(REG_TOTAL_FRAMES, phase_frames[p]);
      repeat (phase_items[p]) begin
        pick_request(op, fr);
        send_beat(op, fr);
        if ($urandom_range(0, 49) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
